// ----- hdl/tsms_pkg.sv -----
// ----------------------------------------------------------------------------
// tsms_pkg
// Types and constants shared by the tempo-scaled melody sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsms_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam int unsigned BASE_TEMPO      = 100;
	localparam logic [15:0] LIMIT_MAX       = 16'hFFFF;

	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_TEMPO   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SILENCE = 2'd2;

	localparam logic [7:0]  TEMPO_RST   = 8'd100;
	localparam logic [6:0]  LENGTH_RST  = 7'd1;
	localparam logic [15:0] SILENCE_RST = 16'd0;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic        play;
		logic [5:0]  entry_index;
		logic [15:0] entry_note;
		logic [15:0] entry_duration;
	} tsms_in_t;

	typedef struct packed {
		logic        tone_on;
		logic [15:0] tone_note;
		logic        finished;
	} tsms_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DIV,
		ST_CHECK,
		ST_FINAL,
		ST_EMIT
	} tsms_state_t;

endpackage

`default_nettype wire

// ----- hdl/tsms_ram.sv -----
// ----------------------------------------------------------------------------
// tsms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsms_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/tempo_scaled_melody_sequencer.sv -----
// ----------------------------------------------------------------------------
// tempo_scaled_melody_sequencer
// Plays a loaded note/duration table on millisecond ticks, each duration
// scaled by 100/tempo through a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  | signals                            | beat
//  ---------+------------------------------------+-----------------------------
//  item     | item_valid, item_stall, item       | load entry or one tick
//  result   | result_valid, result_stall, result | tone state after each item
//  config   | cfg_we, cfg_index, cfg_data        | one register write
//
//  a load or a stop tick goes straight to the result; a play tick may pass
//  through the table read and the restoring divider, at most twice
//  one item is in work at a time; item_stall is high until it is finished
//  the result register holds while result_stall is high; the next item can
//  be taken while it waits
//  arst_n clears control state; the table contents stay undefined
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_scaled_melody_sequencer #(
	parameter int unsigned TABLE_DEPTH = tsms_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire tsms_pkg::tsms_in_t                  item,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output tsms_pkg::tsms_out_t                      result,
	input  wire logic                                cfg_we,
	input  wire logic [tsms_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [tsms_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import tsms_pkg::*;

	localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

	tsms_state_t state_q, state_d;

	logic [7:0]  tempo_q;
	logic [6:0]  length_q;
	logic [15:0] silence_q;

	logic [6:0]  note_index_q;
	logic [15:0] tick_q;
	logic [15:0] limit_q;
	logic        armed_q;
	logic        done_q;
	logic        tone_on_q;
	logic [15:0] tone_note_q;
	logic        first_q;

	logic [7:0]  rem_q;
	logic [15:0] quo_q;
	logic [3:0]  bit_cnt_q;

	logic        result_valid_q;
	tsms_out_t   result_q;

	logic              accept;
	logic              ram_we;
	logic [AddrW-1:0]  ram_waddr;
	logic [AddrW-1:0]  ram_raddr;
	logic [31:0]       ram_rdata;

	logic [8:0]  len;
	logic [6:0]  index_next;
	logic        advance;
	logic        in_melody;
	logic [22:0] dividend;
	logic        saturate;
	logic [8:0]  trial;
	logic        trial_ge;
	logic [8:0]  trial_diff;
	logic        emit_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q   <= TEMPO_RST;
			length_q  <= LENGTH_RST;
			silence_q <= SILENCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMPO:   tempo_q   <= cfg_data[7:0];
				REG_LENGTH:  length_q  <= cfg_data[6:0];
				REG_SILENCE: silence_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept    = item_valid && !item_stall;
	assign ram_we    = accept && (item.cmd == CMD_LOAD)
		&& (9'(item.entry_index) < 9'(TABLE_DEPTH));
	assign ram_waddr = AddrW'(item.entry_index);
	assign ram_raddr = AddrW'(note_index_q);

	tsms_ram #(
		.Width (32),
		.Depth (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({item.entry_note, item.entry_duration}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign len        = (9'(length_q) > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : 9'(length_q);
	assign index_next = note_index_q + 7'd1;
	assign advance    = tick_q >= limit_q;
	assign in_melody  = 9'(index_next) < len;
	assign dividend   = 23'(ram_rdata[15:0]) * 23'(BASE_TEMPO);
	assign saturate   = {1'b0, dividend[22:16]} >= tempo_q;
	assign trial      = {rem_q, quo_q[15]};
	assign trial_ge   = trial >= {1'b0, tempo_q};
	assign trial_diff = trial - {1'b0, tempo_q};
	assign emit_free  = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (item.cmd == CMD_TICK && item.play) begin
						state_d = armed_q ? ST_READ : ST_CHECK;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_READ: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (!saturate) begin
					state_d = ST_DIV;
				end else begin
					state_d = first_q ? ST_CHECK : ST_FINAL;
				end
			end
			ST_DIV: begin
				if (bit_cnt_q == 4'hF) begin
					state_d = first_q ? ST_CHECK : ST_FINAL;
				end
			end
			ST_CHECK: begin
				state_d = (advance && in_melody) ? ST_READ : ST_FINAL;
			end
			ST_FINAL: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_index_q   <= '0;
			tick_q         <= '0;
			limit_q        <= '0;
			armed_q        <= 1'b1;
			done_q         <= 1'b0;
			tone_on_q      <= 1'b0;
			tone_note_q    <= '0;
			first_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && emit_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.cmd == CMD_TICK) begin
						if (item.play) begin
							first_q <= armed_q;
							if (armed_q) begin
								armed_q      <= 1'b0;
								note_index_q <= '0;
								tick_q       <= '0;
								done_q       <= 1'b0;
							end
						end else begin
							armed_q     <= 1'b1;
							tone_on_q   <= 1'b0;
							tone_note_q <= '0;
						end
					end
				end
				ST_MUL: begin
					if (!first_q) begin
						if (ram_rdata[31:16] != silence_q) begin
							tone_on_q   <= 1'b1;
							tone_note_q <= ram_rdata[31:16];
						end else begin
							tone_on_q   <= 1'b0;
							tone_note_q <= '0;
						end
					end
					if (saturate) begin
						limit_q <= LIMIT_MAX;
						first_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (bit_cnt_q == 4'hF) begin
						limit_q <= {quo_q[14:0], trial_ge};
						first_q <= 1'b0;
					end
				end
				ST_CHECK: begin
					if (advance) begin
						note_index_q <= index_next;
						tick_q       <= '0;
					end
				end
				ST_FINAL: begin
					if (9'(note_index_q) >= len) begin
						tone_on_q   <= 1'b0;
						tone_note_q <= '0;
						armed_q     <= 1'b1;
						done_q      <= 1'b1;
					end
					if (tick_q != LIMIT_MAX) begin
						tick_q <= tick_q + 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// divider and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			rem_q     <= dividend[22:16] == 7'd0 ? 8'd0 : {1'b0, dividend[22:16]};
			quo_q     <= dividend[15:0];
			bit_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q     <= trial_ge ? trial_diff[7:0] : trial[7:0];
			quo_q     <= {quo_q[14:0], trial_ge};
			bit_cnt_q <= bit_cnt_q + 4'd1;
		end
		if (state_q == ST_EMIT && emit_free) begin
			result_q.tone_on   <= tone_on_q;
			result_q.tone_note <= tone_note_q;
			result_q.finished  <= done_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- dv/melody_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_check_pkg
// Scoreboard for the tempo-scaled melody sequencer. It keeps its own copy of
// the melody table, the play position and the register settings, works out
// the tone state that each accepted beat leaves behind, and compares every
// result beat against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
package melody_check_pkg;

	import tsms_pkg::*;

	class tone_scoreboard;
		logic [15:0] note_mem [TABLE_DEPTH_DEF];
		logic [15:0] dur_mem [TABLE_DEPTH_DEF];
		logic [7:0]  tempo;
		logic [6:0]  melody_len;
		logic [15:0] silence;
		logic [6:0]  note_idx;
		logic [15:0] ticks;
		logic [15:0] limit;
		bit          armed;
		bit          done_flag;
		bit          tone_on;
		logic [15:0] tone_word;
		tsms_out_t   pending_tones [$];
		int unsigned errors;
		int unsigned items_seen;
		int unsigned tones_checked;

		function new();
			foreach (note_mem[i]) begin
				note_mem[i] = '0;
				dur_mem[i] = '0;
			end
			tempo = TEMPO_RST;
			melody_len = LENGTH_RST;
			silence = SILENCE_RST;
			note_idx = '0;
			ticks = '0;
			limit = '0;
			armed = 1'b1;
			done_flag = 1'b0;
			tone_on = 1'b0;
			tone_word = '0;
			errors = 0;
			items_seen = 0;
			tones_checked = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TEMPO: tempo = data[7:0];
				REG_LENGTH: melody_len = data[6:0];
				REG_SILENCE: silence = data;
				default: ;
			endcase
		endfunction

		// melody length clamped to the table
		function int unsigned span();
			if (melody_len > TABLE_DEPTH_DEF) begin
				return TABLE_DEPTH_DEF;
			end
			return melody_len;
		endfunction

		function logic [15:0] scaled_limit(logic [15:0] dur);
			int unsigned q;
			if (tempo == 0) begin
				return LIMIT_MAX;
			end
			q = (32'(dur) * BASE_TEMPO) / 32'(tempo);
			if (q > 32'(LIMIT_MAX)) begin
				return LIMIT_MAX;
			end
			return q[15:0];
		endfunction

		function void log_item(tsms_in_t it);
			int unsigned len;
			tsms_out_t e;
			len = span();
			items_seen++;
			if (it.cmd == CMD_LOAD) begin
				note_mem[it.entry_index] = it.entry_note;
				dur_mem[it.entry_index] = it.entry_duration;
			end else if (it.play) begin
				if (armed) begin
					armed = 1'b0;
					note_idx = '0;
					ticks = '0;
					done_flag = 1'b0;
					limit = scaled_limit(dur_mem[0]);
				end
				if (ticks >= limit) begin
					note_idx = note_idx + 7'd1;
					if (note_idx < len) begin
						tone_on = (note_mem[note_idx[5:0]] != silence);
						tone_word = tone_on ? note_mem[note_idx[5:0]] : 16'h0000;
						limit = scaled_limit(dur_mem[note_idx[5:0]]);
					end
					ticks = '0;
				end
				if (note_idx >= len) begin
					tone_on = 1'b0;
					tone_word = '0;
					armed = 1'b1;
					done_flag = 1'b1;
				end
				if (ticks != LIMIT_MAX) begin
					ticks = ticks + 16'd1;
				end
			end else begin
				armed = 1'b1;
				tone_on = 1'b0;
				tone_word = '0;
			end
			e.tone_on = tone_on;
			e.tone_note = tone_word;
			e.finished = done_flag;
			pending_tones.push_back(e);
		endfunction

		function void check_tone(tsms_out_t got);
			tsms_out_t want;
			if (pending_tones.size() == 0) begin
				$error("result beat with nothing outstanding: %h", got);
				errors++;
				return;
			end
			want = pending_tones.pop_front();
			tones_checked++;
			if (got.tone_on !== want.tone_on) begin
				$error("tone_on: expected %0d, actual %0d", want.tone_on, got.tone_on);
				errors++;
			end
			if (got.tone_note !== want.tone_note) begin
				$error("tone_note: expected %h, actual %h", want.tone_note, got.tone_note);
				errors++;
			end
			if (got.finished !== want.finished) begin
				$error("finished: expected %0d, actual %0d", want.finished, got.finished);
				errors++;
			end
		endfunction
	endclass

endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and tick beats into the melody sequencer with random gaps and
// output stalls, under a series of tempo, length and rest settings, and
// checks every tone result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;

	import tsms_pkg::*;
	import melody_check_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 60;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	tsms_in_t               item;
	logic                   result_valid;
	logic                   result_stall;
	tsms_out_t              result;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	tone_scoreboard sb;
	bit             idle_on;
	bit             hold_req;
	int unsigned    cycle_count;
	int unsigned    settings_used;

	tempo_scaled_melody_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, one long hold on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_stall = idle_on && ($urandom_range(0, 99) < 24);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_tone(result);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	task automatic send_beat(input tsms_in_t b);
		while (idle_on && $urandom_range(0, 99) < 24) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item = b;
		item_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (item_stall);
		sb.log_item(b);
		@(negedge clk);
	endtask

	task automatic wait_for_tones();
		item_valid = 1'b0;
		while (sb.pending_tones.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_settings(input logic [7:0] t, input logic [6:0] len,
			input logic [15:0] sil);
		wait_for_tones();
		write_reg(REG_TEMPO, CFG_DATA_W'(t));
		write_reg(REG_LENGTH, CFG_DATA_W'(len));
		write_reg(REG_SILENCE, sil);
		cfg_we = 1'b0;
		settings_used++;
	endtask

	function automatic tsms_in_t load_beat(input logic [5:0] idx, input logic [15:0] note,
			input logic [15:0] dur);
		tsms_in_t b;
		b.cmd = CMD_LOAD;
		b.play = 1'($urandom);
		b.entry_index = idx;
		b.entry_note = note;
		b.entry_duration = dur;
		return b;
	endfunction

	function automatic tsms_in_t tick_beat(input logic play);
		tsms_in_t b;
		b.cmd = CMD_TICK;
		b.play = play;
		b.entry_index = 6'($urandom);
		b.entry_note = 16'($urandom);
		b.entry_duration = 16'($urandom);
		return b;
	endfunction

	// durations that keep each note to a few ticks at the current tempo
	function automatic logic [15:0] short_duration();
		int unsigned top;
		top = sb.tempo * ((sb.span() > 16) ? 1 : 4) / BASE_TEMPO;
		return 16'($urandom_range(0, top));
	endfunction

	function automatic logic [15:0] melody_note();
		return ($urandom_range(0, 4) == 0) ? sb.silence : 16'($urandom);
	endfunction

	function automatic tsms_in_t random_beat();
		int unsigned r;
		int unsigned len;
		tsms_in_t b;
		len = sb.span();
		r = $urandom_range(0, 99);
		if (r >= 14) begin
			return tick_beat(1'b1);
		end
		if (r >= 12) begin
			return tick_beat(1'b0);
		end
		b = load_beat(6'($urandom), melody_note(), 16'($urandom));
		if (len != 0 && $urandom_range(0, 3) != 0) begin
			b.entry_index = 6'($urandom_range(0, len - 1));
		end
		if (b.entry_index < len) begin
			b.entry_duration = short_duration();
		end
		return b;
	endfunction

	task automatic play_phase(input logic [7:0] t, input logic [6:0] len, input logic [15:0] sil,
			input int unsigned beats, input bit fill, input bit idle, input bit hold);
		apply_settings(t, len, sil);
		idle_on = idle;
		hold_req = hold;
		if (fill) begin
			for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
				send_beat(load_beat(6'(i), melody_note(), short_duration()));
			end
		end
		repeat (beats) send_beat(random_beat());
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		settings_used = 0;
		sb = new();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: one-entry melody
		send_beat(load_beat(6'd0, 16'hFFFF, 16'd0));
		send_beat(load_beat(6'd1, 16'h0000, 16'd1));
		send_beat(load_beat(6'd2, 16'h8001, 16'd2));
		send_beat(load_beat(6'd3, 16'h1234, 16'hFFFF));
		send_beat(load_beat(6'd63, 16'h5A5A, 16'h8000));
		send_beat(tick_beat(1'b1));
		send_beat(tick_beat(1'b1));
		send_beat(tick_beat(1'b0));

		// zero tempo and zero length
		apply_settings(8'd0, 7'd0, 16'h0000);
		send_beat(tick_beat(1'b1));
		send_beat(tick_beat(1'b0));

		// rest, two notes, then a saturated hold
		apply_settings(8'd50, 7'd4, 16'h0000);
		repeat (9) send_beat(tick_beat(1'b1));
		send_beat(tick_beat(1'b0));

		play_phase(8'd255, 7'd127, 16'hFFFF, 300, 1'b1, 1'b1, 1'b0);
		play_phase(8'd100, 7'd64, 16'($urandom), 300, 1'b0, 1'b0, 1'b0);
		play_phase(8'd1, 7'd2, 16'h0000, 250, 1'b0, 1'b1, 1'b0);
		play_phase(8'd0, 7'd5, 16'($urandom), 80, 1'b0, 1'b1, 1'b0);
		play_phase(8'($urandom_range(1, 255)), 7'($urandom_range(1, 64)), 16'($urandom),
			320, 1'b0, 1'b1, 1'b1);
		play_phase(8'($urandom_range(1, 255)), 7'($urandom_range(1, 8)), 16'h0000,
			300, 1'b0, 1'b1, 1'b0);
		play_phase(8'($urandom_range(1, 255)), 7'd0, 16'($urandom), 80, 1'b0, 1'b1, 1'b0);

		wait_for_tones();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d beats played and %0d tone results compared across %0d register settings",
			sb.items_seen, sb.tones_checked, settings_used);
		$display("settings spanned tempo 0 to 255, length 0 to 127, rests and saturated notes");
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
